@@ hw/rtl/swm_pkg.sv @@
// swm_pkg: shared types and constants of the sliding window median filter
// used by swm_window and sliding_window_median; depends on nothing else
`default_nettype none

package swm_pkg;

  // width of the window size register
  localparam int unsigned WsBits = 6;

  // update strobe from the control path into the sorted window
  typedef struct packed {
    logic write;  // a request updates the window this cycle
    logic full;   // window already full: oldest sample leaves
  } swm_upd_t;

endpackage

`default_nettype wire

@@ hw/rtl/swm_window.sv @@
// swm_window: sorted cell array of the median filter, one insert/evict per cycle
// while upd_i.write is high; depends on swm_pkg
`default_nettype none

module swm_window
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1),
  localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  wire                          clk_i,
  input  swm_upd_t                     upd_i,
  input  wire signed [SAMPLE_BITS-1:0] sample_i,
  input  wire        [CW-1:0]          count_i,
  input  wire        [CW-1:0]          win_i,
  input  wire        [IW-1:0]          mid_i,
  output logic signed [SAMPLE_BITS-1:0] mid_value_o
);

  localparam int unsigned N = MAX_WINDOW;

  // cell contents: value in ascending order and age in requests
  logic signed [SAMPLE_BITS-1:0] val_q [N];
  logic        [IW-1:0]          age_q [N];
  logic signed [SAMPLE_BITS-1:0] val_d [N];
  logic        [IW-1:0]          age_d [N];

  logic [N-1:0] held;      // cell holds a window sample
  logic [N-1:0] evict;     // cell holds the oldest sample and leaves
  logic [N-1:0] evict_le;  // eviction at or below this cell
  logic [N-1:0] le;        // cell value not above the new sample
  logic [N-1:0] comp_ok;   // compacted cell is valid
  logic [N-1:0] take_c;    // compacted cell stays below the new sample

  logic signed [SAMPLE_BITS-1:0] comp_val [N];
  logic        [IW-1:0]          comp_age [N];
  logic        [N-1:0]           comp_le;

  logic [CW-1:0] win_m1;
  logic [CW-1:0] kept;

  assign win_m1 = win_i - CW'(1);
  assign kept   = upd_i.full ? (count_i - CW'(1)) : count_i;

  // per cell compare and shift selection
  for (genvar k = 0; k < N; k++) begin : g_cell
    assign held[k]    = CW'(k) < count_i;
    assign evict[k]   = upd_i.full && held[k] && (age_q[k] == win_m1[IW-1:0]);
    assign evict_le[k] = |evict[k:0];
    assign le[k]      = val_q[k] <= sample_i;
    assign comp_ok[k] = CW'(k) < kept;

    // compacted view: cells above the evicted one move down by one
    if (k < N - 1) begin : g_mid
      assign comp_val[k] = evict_le[k] ? val_q[k+1] : val_q[k];
      assign comp_age[k] = evict_le[k] ? age_q[k+1] : age_q[k];
      assign comp_le[k]  = evict_le[k] ? le[k+1]    : le[k];
    end else begin : g_top
      assign comp_val[k] = val_q[k];
      assign comp_age[k] = age_q[k];
      assign comp_le[k]  = le[k];
    end

    assign take_c[k] = comp_ok[k] && comp_le[k];

    // insert the new sample right after the last compacted value not above it
    if (k == 0) begin : g_first
      always_comb begin
        if (take_c[k]) begin
          val_d[k] = comp_val[k];
          age_d[k] = comp_age[k] + IW'(1);
        end else begin
          val_d[k] = sample_i;
          age_d[k] = '0;
        end
      end
    end else begin : g_rest
      always_comb begin
        if (take_c[k]) begin
          val_d[k] = comp_val[k];
          age_d[k] = comp_age[k] + IW'(1);
        end else if (take_c[k-1]) begin
          val_d[k] = sample_i;
          age_d[k] = '0;
        end else begin
          val_d[k] = comp_val[k-1];
          age_d[k] = comp_age[k-1] + IW'(1);
        end
      end
    end
  end

  // cell registers, payload only
  always_ff @(posedge clk_i) begin
    if (upd_i.write) begin
      for (int k = 0; k < N; k++) begin
        val_q[k] <= val_d[k];
        age_q[k] <= age_d[k];
      end
    end
  end

  // median tap
  assign mid_value_o = val_q[mid_i];

endmodule

`default_nettype wire

@@ hw/rtl/sliding_window_median.sv @@
// sliding_window_median: top level of the sliding window median filter
// depends on swm_pkg and swm_window
//
// Usage: one signed sample per request on the input channel (in_valid_i,
// in_stall_o, in_sample_i, in_restart_i). The block keeps the last
// window_size samples in a sorted cell array; once the window is full each
// request yields one result (out_valid_o, out_stall_i, out_median_o), the
// lower median at sorted place (window_size-1)/2. Requests that only fill
// the window yield nothing. in_restart_i empties the window first.
// window_size is written through cfg_we_i/cfg_data_i while the block is idle;
// zero acts as 1, values above MAX_WINDOW act as MAX_WINDOW, and every write
// empties the window. Reset sets window_size to 3, or to MAX_WINDOW if that is
// smaller, and empties the window. A taken request passes the input register,
// then the cell update with the pending flag, then the median register, where
// out_valid_o rises. One request per cycle is taken sustained while out_stall_i
// stays low; the sorted cells compare and shift in parallel.
// When the receiver stalls, the result register holds and one pending
// request plus one in the input register are kept before in_stall_o rises.
`default_nettype none

module sliding_window_median
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire        [WsBits-1:0]       cfg_data_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire signed [SAMPLE_BITS-1:0]  in_sample_i,
  input  wire                           in_restart_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] out_median_o
);

  localparam int unsigned CW     = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned RstWin = (MAX_WINDOW < 3) ? MAX_WINDOW : 3;
  localparam int unsigned RstMid = (RstWin - 1) / 2;

  logic [CW-1:0] win_q, win_d;
  logic [IW-1:0] mid_q, mid_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic                          in_valid_q;
  logic signed [SAMPLE_BITS-1:0] in_sample_q;
  logic                          in_restart_q;
  logic                          pend_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_median_q;

  logic                          in_take, s1_fire, p_move, out_take;
  logic [CW-1:0]                 n_cur, n_new;
  logic                          full, emit;
  logic signed [SAMPLE_BITS-1:0] mid_value;
  swm_upd_t                      upd;

  // effective window size from a register write
  always_comb begin
    if (cfg_data_i == '0) begin
      win_d = CW'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_WINDOW)) begin
      win_d = CW'(MAX_WINDOW);
    end else begin
      win_d = CW'(cfg_data_i);
    end
    mid_d = IW'((win_d - CW'(1)) >> 1);
  end

  // pipeline handshake
  assign out_take = out_valid_q && !out_stall_i;
  assign p_move   = pend_q && (!out_valid_q || !out_stall_i);
  assign s1_fire  = in_valid_q && (!pend_q || p_move);
  assign in_stall_o = in_valid_q && !s1_fire;
  assign in_take  = in_valid_i && !in_stall_o;

  // fill count after restart, and what this request leaves
  always_comb begin
    n_cur = in_restart_q ? '0 : cnt_q;
    if (n_cur > win_q) begin
      n_cur = '0;
    end
    full  = (n_cur == win_q);
    n_new = full ? win_q : (n_cur + CW'(1));
    emit  = (n_new == win_q);
    cnt_d = n_new;
  end

  assign upd.write = s1_fire;
  assign upd.full  = full;

  // sorted window
  swm_window #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i       (clk_i),
    .upd_i       (upd),
    .sample_i    (in_sample_q),
    .count_i     (n_cur),
    .win_i       (win_q),
    .mid_i       (mid_q),
    .mid_value_o (mid_value)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= CW'(RstWin);
      mid_q       <= IW'(RstMid);
      cnt_q       <= '0;
      in_valid_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= win_d;
        mid_q <= mid_d;
        cnt_q <= '0;
      end else if (s1_fire) begin
        cnt_q <= cnt_d;
      end

      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (s1_fire) begin
        in_valid_q <= 1'b0;
      end

      if (s1_fire) begin
        pend_q <= emit;
      end else if (p_move) begin
        pend_q <= 1'b0;
      end

      if (p_move) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sample_q  <= in_sample_i;
      in_restart_q <= in_restart_i;
    end
    if (p_move) begin
      out_median_q <= mid_value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_median_o = out_median_q;

  // fill count never passes the window size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= win_q)
    else $error("fill count above window size");

  // a pending median always belongs to a full window
  a_pend_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (cnt_q == win_q))
    else $error("median pending on a partial window");

  // a new result only comes from a pending median
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pend_q))
    else $error("result without pending median");

endmodule

`default_nettype wire

@@ dv/sliding_window_median_tb.sv @@
// sliding_window_median_tb: self-checking testbench of the sliding window median filter
// depends on swm_pkg and sliding_window_median; keeps its own sorted window and checks
// every median in order while both channels idle and stall at random
module sliding_window_median_tb;
  import swm_pkg::*;

  localparam int unsigned MaxWindow     = 32;
  localparam int unsigned SampleBits    = 16;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned SweepItems    = 100;
  localparam int unsigned FullRateItems = 250;

  typedef logic signed [SampleBits-1:0] sample_t;

  localparam logic [WsBits-1:0] ResetWindow = 3;
  localparam sample_t SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleBits-1){1'b0}}};

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [WsBits-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  sample_t           in_sample_i;
  logic              in_restart_i;
  logic              out_valid_o;
  logic              out_stall_i;
  sample_t           out_median_o;

  // own copy of the window: configuration, arrival ring and sorted list
  logic [WsBits-1:0] window_reg;
  sample_t           arrival_ring [MaxWindow];
  sample_t           sorted_win   [MaxWindow];
  int unsigned       fill_cnt;
  int unsigned       oldest_ptr;
  sample_t           expected_medians [$];

  int unsigned       err_count;
  bit                tx_idle_en;
  bit                rx_idle_en;
  int unsigned       hold_left;

  sliding_window_median #(
    .MAX_WINDOW (MaxWindow),
    .SAMPLE_BITS(SampleBits)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_sample_i (in_sample_i),
    .in_restart_i(in_restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_median_o(out_median_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // update the window with one accepted sample and queue the median it yields
  function automatic void predict_median(input sample_t smp, input logic restart);
    int unsigned w;
    int unsigned n;
    int unsigned i;
    int unsigned j;
    sample_t     old;
    w = (window_reg == 0) ? 1 : ((window_reg > MaxWindow) ? MaxWindow : window_reg);
    if (restart || fill_cnt > w) begin
      fill_cnt   = 0;
      oldest_ptr = 0;
    end
    if (oldest_ptr >= w) oldest_ptr = 0;
    if (fill_cnt < w) begin
      arrival_ring[fill_cnt] = smp;
      n = fill_cnt;
      fill_cnt++;
    end else begin
      // oldest sample leaves the ring and one matching sorted entry
      old = arrival_ring[oldest_ptr];
      arrival_ring[oldest_ptr] = smp;
      oldest_ptr = (oldest_ptr + 1 >= w) ? 0 : oldest_ptr + 1;
      j = 0;
      while (j < w && sorted_win[j] != old) j++;
      if (j >= w) j = w - 1;
      while (j + 1 < w) begin
        sorted_win[j] = sorted_win[j+1];
        j++;
      end
      n = w - 1;
    end
    // insertion into the sorted list of n entries
    i = n;
    while (i > 0 && sorted_win[i-1] > smp) begin
      sorted_win[i] = sorted_win[i-1];
      i--;
    end
    sorted_win[i] = smp;
    if (fill_cnt == w) expected_medians = {expected_medians, sorted_win[(w-1)/2]};
  endfunction

  // sample mix: extremes, a narrow band for ties, full range
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       rand_sample = $urandom_range(0, 1) ? SampleMax : SampleMin;
      1, 2:    rand_sample = sample_t'($urandom_range(0, 8)) - sample_t'(4);
      default: rand_sample = sample_t'($urandom);
    endcase
  endfunction

  // offer one request, wait for it to be taken, then predict
  task automatic send_sample(input sample_t smp, input logic restart);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    in_sample_i  = smp;
    in_restart_i = restart;
    forever begin
      @(posedge clk_i);
      if (in_stall_o === 1'b0) break;
    end
    predict_median(smp, restart);
  endtask

  // stop sending and wait until every median has come and the pipeline is empty
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_medians.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // window size write, only with the block idle
  task automatic write_window(input logic [WsBits-1:0] value);
    settle_block();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    window_reg = value;
    fill_cnt   = 0;
    oldest_ptr = 0;
  endtask

  // extremes, restart, ties, window of zero and even window
  task automatic test_directed();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    // reset window of three
    send_sample(16'sd0, 1'b1);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd5, 1'b1);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(SampleMax, 1'b0);
    // zero acts as a window of one
    write_window(0);
    send_sample(SampleMin, 1'b0);
    send_sample(SampleMax, 1'b1);
    send_sample(-16'sd7, 1'b0);
    // even window gives the lower middle value
    write_window(2);
    send_sample(16'sd10, 1'b0);
    send_sample(-16'sd10, 1'b0);
    send_sample(16'sd20, 1'b0);
    send_sample(-16'sd30, 1'b0);
  endtask

  // random samples over a series of window sizes, saturating ones included
  task automatic test_window_sweep();
    logic [WsBits-1:0] sizes [12] = '{1, 3, 0, 2, 4, 7, 16, 31, 32, 33, 63, 5};
    int unsigned       k;
    int unsigned       n;
    sizes[11] = WsBits'($urandom_range(0, 63));
    for (k = 0; k < 12; k++) begin
      write_window(sizes[k]);
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      for (n = 0; n < SweepItems; n++) send_sample(rand_sample(), $urandom_range(0, 49) == 0);
    end
  endtask

  // receiver holds off long enough for the input to stall, then the sender drains
  task automatic test_output_hold();
    int unsigned n;
    write_window(5);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_left  = HoldCycles;
    for (n = 0; n < 40; n++) send_sample(rand_sample(), 1'b0);
    settle_block();
    for (n = 0; n < 20; n++) send_sample(rand_sample(), $urandom_range(0, 9) == 0);
  endtask

  // back to back requests with no idling on either side
  task automatic test_full_rate();
    int unsigned n;
    write_window(WsBits'($urandom_range(1, 32)));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (n = 0; n < FullRateItems; n++) send_sample(rand_sample(), $urandom_range(0, 99) == 0);
  endtask

  // stimulus sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    in_sample_i  = '0;
    in_restart_i = 1'b0;
    err_count    = 0;
    tx_idle_en   = 1'b0;
    rx_idle_en   = 1'b0;
    hold_left    = 0;
    window_reg   = ResetWindow;
    fill_cnt     = 0;
    oldest_ptr   = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_window_sweep();
    test_output_hold();
    test_full_rate();
    settle_block();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver: long hold-off on request, otherwise random stall bursts
  initial begin
    int unsigned burst_left;
    burst_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (burst_left != 0) begin
        out_stall_i = 1'b1;
        burst_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        burst_left  = $urandom_range(0, 3);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // result check against the oldest expected median
  initial begin
    sample_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        if (expected_medians.size() == 0) begin
          $error("median: expected none, actual %0d", out_median_o);
          err_count++;
        end else begin
          want = expected_medians.pop_front();
          if (out_median_o !== want) begin
            $error("median: expected %0d, actual %0d", want, out_median_o);
            err_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no request taken on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
